// ===== rtl/tbbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbbs_pkg
// Shared constants and types of the tiled bilinear blend sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tbbs_pkg;

  localparam int TILE_SIZE   = 64;
  localparam int TILE_BORDER = 2;
  localparam int TILE_SLOTS  = 64;
  localparam int GRID_TILES  = 64;

  localparam int TILE_EXTENT = TILE_SIZE + 2 * TILE_BORDER;
  localparam int TILE_TEXELS = TILE_EXTENT * TILE_EXTENT;
  localparam int HALF_EXTENT = (TILE_EXTENT + 1) / 2;
  localparam int SLOT_TEXELS = HALF_EXTENT * HALF_EXTENT;
  localparam int BANK_DEPTH  = TILE_SLOTS * SLOT_TEXELS;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int PART_W      = $clog2(SLOT_TEXELS);

  localparam int DIR_DEPTH = GRID_TILES * GRID_TILES;
  localparam int DIR_AW    = $clog2(DIR_DEPTH);
  localparam int SLOT_W    = 6;
  localparam int DIR_W     = SLOT_W + 2;

  localparam int ONE_Q16 = 65536;

  // index / TILE_EXTENT as a reciprocal multiply, exact for index < 8192
  localparam int RECIP_M = 7711;
  localparam int RECIP_S = 19;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_TEXEL = 2'd1;
  localparam logic [1:0] KIND_DIR   = 2'd2;

  typedef struct packed {
    logic        vld;
    logic        miss;
    logic        ox0;
    logic        oz0;
    logic [15:0] fx;
    logic [15:0] fz;
  } tap_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tiled_bilinear_blend_sampler.sv =====
// ----------------------------------------------------------------------------
// tiled_bilinear_blend_sampler
// Sparse tiled blend field sampler with smoothstep and gradient output.
// ----------------------------------------------------------------------------
// An item is a transfer at a clock edge with start_i high and busy_o low.
// kind_i selects a query, a texel write or a tile directory write. Only
// queries give a result: done_o is high for one cycle with hit_o, blend_o
// and the two gradients. One item is taken every cycle while busy_o is
// low; writes take effect for every later query.
// The pipeline never stalls and the receiver cannot hold results off.
// Registers (field_resolution at 0x0, texels_per_meter at 0x4) are set over
// the APB port while no item is in flight; pready is always high.
// After reset busy_o stays high while all 4096 directory entries are
// swept clear, one entry a cycle; register writes are taken meanwhile.
// Texels must be written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_bilinear_blend_sampler (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic signed [31:0] world_x_i,
  input  wire logic signed [31:0] world_z_i,
  input  wire logic [5:0]         slot_i,
  input  wire logic [12:0]        texel_index_i,
  input  wire logic [16:0]        texel_value_i,
  input  wire logic [5:0]         tile_x_i,
  input  wire logic [5:0]         tile_z_i,
  input  wire logic               entry_present_i,
  input  wire logic               entry_has_river_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic [16:0]             blend_o,
  output logic signed [31:0]      gradient_x_o,
  output logic signed [31:0]      gradient_z_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic REG_FIELD_RES = 1'b0;
  localparam logic REG_TPM       = 1'b1;
  localparam int   LATENCY       = 11;
  localparam logic [30:0] AX_OFS = 31'((tbbs_pkg::TILE_BORDER << 24) - (1 << 23));
  localparam int   TSH           = 24 + $clog2(tbbs_pkg::TILE_SIZE);
  localparam int   PART_W        = tbbs_pkg::PART_W;

  logic [14:0] field_res_q;
  logic [23:0] tpm_q;
  logic        accept;
  logic        cfg_we;

  // stage 1
  logic               s1_vld_q;
  logic [1:0]         s1_kind_q;
  logic signed [31:0] s1_wx_q, s1_wz_q;
  logic [5:0]         s1_slot_q;
  logic [12:0]        s1_idx_q;
  logic [16:0]        s1_val_q;
  logic [5:0]         s1_tx_q, s1_tz_q;
  logic               s1_pres_q, s1_river_q;
  // stage 2
  logic               s2_vld_q;
  logic [1:0]         s2_kind_q;
  logic [57:0]        s2_px_q, s2_pz_q;
  logic [5:0]         s2_slot_q;
  logic [12:0]        s2_idx_q;
  logic [6:0]         s2_quot_q;
  logic [16:0]        s2_val_q;
  logic [5:0]         s2_tx_q, s2_tz_q;
  logic               s2_pres_q, s2_river_q;
  // stage 3
  logic               s3_vld_q;
  logic               s3_miss_q;
  logic               s3_ox0_q, s3_oz0_q;
  logic [15:0]        s3_fx_q, s3_fz_q;
  logic [3:0][tbbs_pkg::PART_W-1:0] s3_part_q;
  logic               s3_tw_q;
  logic [1:0]         s3_tw_bank_q;
  logic [tbbs_pkg::PART_W-1:0] s3_tw_part_q;
  logic [5:0]         s3_tw_slot_q;
  logic [16:0]        s3_tw_val_q;
  // stage 4
  tbbs_pkg::tap_ctrl_t s4_ctrl_q;

  logic signed [56:0] prodx, prodz;
  logic [57:0]        limit;
  logic               in_x, in_z, cfg_ok;
  logic [30:0]        ax, az;
  logic [6:0]         ox, oz, ox1, oz1;
  logic [1:0][5:0]    colx, rowz;
  logic [3:0][tbbs_pkg::PART_W-1:0] part_d;
  logic [6:0]         rem;
  logic [25:0]        quot_full;
  logic [16:0]        val_sat;
  logic [tbbs_pkg::DIR_W-1:0] dir_entry;
  logic               dir_clearing;
  logic               dir_we;
  logic [3:0][tbbs_pkg::BANK_AW-1:0] rd_addr;
  logic [tbbs_pkg::BANK_AW-1:0] tw_addr;
  logic [3:0][16:0]   tap_data;
  logic [5:0]         hit_slot;

  assign busy_o = dir_clearing;
  assign accept = start_i & ~busy_o;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[2])
      REG_FIELD_RES: prdata = {17'b0, field_res_q};
      REG_TPM:       prdata = {8'b0, tpm_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_res_q <= '0;
      tpm_q       <= '0;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_FIELD_RES: field_res_q <= pwdata[14:0];
        REG_TPM:       tpm_q       <= pwdata[23:0];
        default:       ;
      endcase
    end
  end

  assign val_sat = (texel_value_i > 17'(tbbs_pkg::ONE_Q16)) ?
                   17'(tbbs_pkg::ONE_Q16) : texel_value_i;

  always_comb begin
    prodx     = s1_wx_q * $signed({1'b0, tpm_q});
    prodz     = s1_wz_q * $signed({1'b0, tpm_q});
    quot_full = 26'(s1_idx_q) * 26'(tbbs_pkg::RECIP_M);

    limit  = {19'b0, field_res_q, 24'b0};
    cfg_ok = (field_res_q != '0) && (tpm_q != '0);
    in_x   = ~s2_px_q[57] && (s2_px_q < limit) &&
             (s2_px_q[57:TSH] < (58 - TSH)'(tbbs_pkg::GRID_TILES));
    in_z   = ~s2_pz_q[57] && (s2_pz_q < limit) &&
             (s2_pz_q[57:TSH] < (58 - TSH)'(tbbs_pkg::GRID_TILES));

    // position inside the bordered tile, half a texel back to the tap centre
    ax  = 31'(s2_px_q[TSH-1:0]) + AX_OFS;
    az  = 31'(s2_pz_q[TSH-1:0]) + AX_OFS;
    ox  = ax[30:24];
    oz  = az[30:24];
    ox1 = ox + 7'd1;
    oz1 = oz + 7'd1;
    // the tap pair always lies inside the bordered tile, so no clamp bites
    for (int p = 0; p < 2; p++) begin
      colx[p] = (ox[0] == 1'(p)) ? ox[6:1] : ox1[6:1];
      rowz[p] = (oz[0] == 1'(p)) ? oz[6:1] : oz1[6:1];
    end
    for (int b = 0; b < 4; b++) begin
      part_d[b] = PART_W'(PART_W'(rowz[b / 2]) * PART_W'(tbbs_pkg::HALF_EXTENT)
                  + PART_W'(colx[b % 2]));
    end

    rem = 7'(s2_idx_q - 13'(s2_quot_q) * 13'(tbbs_pkg::TILE_EXTENT));
  end

  assign dir_we = s2_vld_q && (s2_kind_q == tbbs_pkg::KIND_DIR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s3_tw_q   <= 1'b0;
      s4_ctrl_q <= '0;
    end else begin
      s1_vld_q  <= accept;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q && (s2_kind_q == tbbs_pkg::KIND_QUERY);
      s3_tw_q   <= s2_vld_q && (s2_kind_q == tbbs_pkg::KIND_TEXEL) &&
                   (s2_idx_q < 13'(tbbs_pkg::TILE_TEXELS));
      s4_ctrl_q <= '{vld:  s3_vld_q,
                     miss: s3_miss_q || (dir_entry[1:0] != 2'b11),
                     ox0:  s3_ox0_q,
                     oz0:  s3_oz0_q,
                     fx:   s3_fx_q,
                     fz:   s3_fz_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= kind_i;
      s1_wx_q    <= world_x_i;
      s1_wz_q    <= world_z_i;
      s1_slot_q  <= slot_i;
      s1_idx_q   <= texel_index_i;
      s1_val_q   <= val_sat;
      s1_tx_q    <= tile_x_i;
      s1_tz_q    <= tile_z_i;
      s1_pres_q  <= entry_present_i;
      s1_river_q <= entry_has_river_i;
    end

    s2_kind_q  <= s1_kind_q;
    s2_px_q    <= {prodx[56], prodx} + {20'b0, field_res_q, 23'b0};
    s2_pz_q    <= {prodz[56], prodz} + {20'b0, field_res_q, 23'b0};
    s2_slot_q  <= s1_slot_q;
    s2_idx_q   <= s1_idx_q;
    s2_quot_q  <= quot_full[tbbs_pkg::RECIP_S +: 7];
    s2_val_q   <= s1_val_q;
    s2_tx_q    <= s1_tx_q;
    s2_tz_q    <= s1_tz_q;
    s2_pres_q  <= s1_pres_q;
    s2_river_q <= s1_river_q;

    s3_miss_q    <= ~(cfg_ok && in_x && in_z);
    s3_ox0_q     <= ox[0];
    s3_oz0_q     <= oz[0];
    s3_fx_q      <= ax[23:8];
    s3_fz_q      <= az[23:8];
    s3_part_q    <= part_d;
    s3_tw_bank_q <= {s2_quot_q[0], rem[0]};
    s3_tw_part_q <= PART_W'(PART_W'(s2_quot_q[6:1]) * PART_W'(tbbs_pkg::HALF_EXTENT)
                    + PART_W'(rem[6:1]));
    s3_tw_slot_q <= s2_slot_q;
    s3_tw_val_q  <= s2_val_q;
  end

  tbbs_dir u_dir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (dir_we),
    .wr_addr_i  ({s2_tz_q, s2_tx_q}),
    .wr_data_i  ({s2_slot_q, s2_river_q, s2_pres_q}),
    .rd_addr_i  ({s2_pz_q[TSH +: 6], s2_px_q[TSH +: 6]}),
    .rd_data_o  (dir_entry),
    .clearing_o (dir_clearing)
  );

  assign hit_slot = dir_entry[tbbs_pkg::DIR_W-1:2];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = tbbs_pkg::BANK_AW'(tbbs_pkg::BANK_AW'(hit_slot)
                   * tbbs_pkg::BANK_AW'(tbbs_pkg::SLOT_TEXELS)
                   + tbbs_pkg::BANK_AW'(s3_part_q[b]));
    end
    tw_addr = tbbs_pkg::BANK_AW'(tbbs_pkg::BANK_AW'(s3_tw_slot_q)
              * tbbs_pkg::BANK_AW'(tbbs_pkg::SLOT_TEXELS)
              + tbbs_pkg::BANK_AW'(s3_tw_part_q));
  end

  tbbs_texmem u_texmem (
    .clk_i     (clk_i),
    .wr_en_i   (s3_tw_q),
    .wr_bank_i (s3_tw_bank_q),
    .wr_addr_i (tw_addr),
    .wr_data_i (s3_tw_val_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (tap_data)
  );

  tbbs_filter u_filter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tpm_i        (tpm_q),
    .ctrl_i       (s4_ctrl_q),
    .tap_i        (tap_data),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .blend_o      (blend_o),
    .gradient_x_o (gradient_x_o),
    .gradient_z_o (gradient_z_o)
  );

  // a result comes only from a query taken a fixed latency earlier
  a_done_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && (kind_i == tbbs_pkg::KIND_QUERY), LATENCY))
    else $error("result without a matching query");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (blend_o == '0 && gradient_x_o == '0 && gradient_z_o == '0))
    else $error("miss result carries nonzero data");

  a_blend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (blend_o <= 17'(tbbs_pkg::ONE_Q16)))
    else $error("blend above one");

endmodule

`default_nettype wire

// ===== rtl/tbbs_dir.sv =====
// ----------------------------------------------------------------------------
// tbbs_dir
// Tile directory memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tbbs_dir (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [tbbs_pkg::DIR_AW-1:0]  wr_addr_i,
  input  wire logic [tbbs_pkg::DIR_W-1:0]   wr_data_i,
  input  wire logic [tbbs_pkg::DIR_AW-1:0]  rd_addr_i,
  output logic      [tbbs_pkg::DIR_W-1:0]   rd_data_o,
  output logic                              clearing_o
);

  logic [tbbs_pkg::DIR_AW:0]   clr_cnt_q, clr_cnt_d;
  logic [tbbs_pkg::DIR_W-1:0]  mem [tbbs_pkg::DIR_DEPTH];
  logic                        we;
  logic [tbbs_pkg::DIR_AW-1:0] wa;
  logic [tbbs_pkg::DIR_W-1:0]  wd;

  assign clearing_o = ~clr_cnt_q[tbbs_pkg::DIR_AW];
  assign clr_cnt_d  = clearing_o ? clr_cnt_q + 1'b1 : clr_cnt_q;

  always_comb begin
    if (clearing_o) begin
      we = 1'b1;
      wa = clr_cnt_q[tbbs_pkg::DIR_AW-1:0];
      wd = '0;
    end else begin
      we = wr_en_i;
      wa = wr_addr_i;
      wd = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/tbbs_texmem.sv =====
// ----------------------------------------------------------------------------
// tbbs_texmem
// Texel store in four banks split by row and column parity.
// ----------------------------------------------------------------------------
`default_nettype none

module tbbs_texmem (
  input  wire logic                                 clk_i,
  input  wire logic                                 wr_en_i,
  input  wire logic [1:0]                           wr_bank_i,
  input  wire logic [tbbs_pkg::BANK_AW-1:0]         wr_addr_i,
  input  wire logic [16:0]                          wr_data_i,
  input  wire logic [3:0][tbbs_pkg::BANK_AW-1:0]    rd_addr_i,
  output logic      [3:0][16:0]                     rd_data_o
);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [16:0] mem [tbbs_pkg::BANK_DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank_i == 2'(b))) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      rd_data_o[b] <= mem[rd_addr_i[b]];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tbbs_filter.sv =====
// ----------------------------------------------------------------------------
// tbbs_filter
// Bilinear filter, smoothstep and gradient scaling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tbbs_filter (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [23:0]          tpm_i,
  input  wire tbbs_pkg::tap_ctrl_t  ctrl_i,
  input  wire logic [3:0][16:0]     tap_i,
  output logic                      done_o,
  output logic                      hit_o,
  output logic [16:0]               blend_o,
  output logic signed [31:0]        gradient_x_o,
  output logic signed [31:0]        gradient_z_o
);

  function automatic logic signed [34:0] rnd_q(input logic signed [58:0] x);
    logic [58:0] mag;
    logic [58:0] r;
    mag = x[58] ? 59'(-x) : 59'(x);
    r   = (mag + 59'(1 << 23)) >> 24;
    return x[58] ? -$signed(r[34:0]) : $signed(r[34:0]);
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [52:0] x);
    logic [52:0] mag;
    logic [52:0] r;
    mag = x[52] ? 53'(-x) : 53'(x);
    r   = (mag + 53'(1 << 23)) >> 24;
    if (x[52]) begin
      return (r > 53'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(r[31:0]);
    end
    return (r > 53'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(r[31:0]);
  endfunction

  typedef struct packed {
    logic vld;
    logic miss;
  } flow_t;

  // stage a
  flow_t              a_fl_q;
  logic [32:0]        a_top_q, a_bot_q;
  logic signed [33:0] a_rawx_q, a_rawz_q;
  logic [15:0]        a_fz_q;
  // stage b
  flow_t              b_fl_q;
  logic [49:0]        b_wq_q;
  logic signed [58:0] b_pgx_q, b_pgz_q;
  // stage c
  flow_t              c_fl_q;
  logic [16:0]        c_w_q;
  logic signed [34:0] c_qx_q, c_qz_q;
  // stage d
  flow_t              d_fl_q;
  logic [33:0]        d_ww_q;
  logic [17:0]        d_t_q;
  logic [33:0]        d_wk_q;
  logic signed [34:0] d_qx_q, d_qz_q;
  // stage e
  flow_t              e_fl_q;
  logic [51:0]        e_s_q;
  logic [16:0]        e_k_q;
  logic signed [34:0] e_qx_q, e_qz_q;
  // stage f
  flow_t              f_fl_q;
  logic [16:0]        f_blend_q;
  logic signed [52:0] f_gx_q, f_gz_q;
  // output
  flow_t              o_fl_q;
  logic [16:0]        o_blend_q;
  logic signed [31:0] o_gx_q, o_gz_q;

  logic [16:0]        v0, v1, v2, v3;
  logic [16:0]        omfx, omfz, a_omfz;
  logic signed [17:0] dx0, dx1, dz0, dz1;
  logic [50:0]        wq_rnd;
  logic [17:0]        w_full;
  logic [16:0]        w_d;
  logic [16:0]        omw;
  logic [52:0]        s_rnd;
  logic [19:0]        bl_full;
  logic [35:0]        k_sum;

  // route banks to taps by the parity of the base tap
  always_comb begin
    v0 = tap_i[{ctrl_i.oz0,  ctrl_i.ox0}];
    v1 = tap_i[{ctrl_i.oz0, ~ctrl_i.ox0}];
    v2 = tap_i[{~ctrl_i.oz0,  ctrl_i.ox0}];
    v3 = tap_i[{~ctrl_i.oz0, ~ctrl_i.ox0}];
    omfx = 17'(tbbs_pkg::ONE_Q16) - {1'b0, ctrl_i.fx};
    omfz = 17'(tbbs_pkg::ONE_Q16) - {1'b0, ctrl_i.fz};
    dx0 = $signed({1'b0, v1}) - $signed({1'b0, v0});
    dx1 = $signed({1'b0, v3}) - $signed({1'b0, v2});
    dz0 = $signed({1'b0, v2}) - $signed({1'b0, v0});
    dz1 = $signed({1'b0, v3}) - $signed({1'b0, v1});
    a_omfz = 17'(tbbs_pkg::ONE_Q16) - {1'b0, a_fz_q};
    wq_rnd = {1'b0, b_wq_q} + 51'(64'h8000_0000);
    w_full = wq_rnd[49:32];
    w_d    = (w_full > 18'(tbbs_pkg::ONE_Q16)) ? 17'(tbbs_pkg::ONE_Q16) : w_full[16:0];
    omw    = 17'(tbbs_pkg::ONE_Q16) - c_w_q;
    s_rnd  = {1'b0, e_s_q} + 53'(64'h8000_0000);
    bl_full = s_rnd[51:32];
    k_sum  = 36'(d_wk_q) * 36'(6) + 36'(32768);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_fl_q <= '0;
      b_fl_q <= '0;
      c_fl_q <= '0;
      d_fl_q <= '0;
      e_fl_q <= '0;
      f_fl_q <= '0;
      o_fl_q <= '0;
    end else begin
      a_fl_q <= '{vld: ctrl_i.vld, miss: ctrl_i.miss};
      b_fl_q <= a_fl_q;
      c_fl_q <= b_fl_q;
      d_fl_q <= c_fl_q;
      e_fl_q <= d_fl_q;
      f_fl_q <= e_fl_q;
      o_fl_q <= f_fl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_top_q  <= 33'(34'(v0) * 34'(omfx) + 34'(v1) * 34'(ctrl_i.fx));
    a_bot_q  <= 33'(34'(v2) * 34'(omfx) + 34'(v3) * 34'(ctrl_i.fx));
    a_rawx_q <= 34'(dx0 * $signed({1'b0, omfz}) + dx1 * $signed({2'b0, ctrl_i.fz}));
    a_rawz_q <= 34'(dz0 * $signed({1'b0, omfx}) + dz1 * $signed({2'b0, ctrl_i.fx}));
    a_fz_q   <= ctrl_i.fz;

    b_wq_q  <= 50'(50'(a_top_q) * 50'(a_omfz) + 50'(a_bot_q) * 50'(a_fz_q));
    b_pgx_q <= 59'(a_rawx_q * $signed({1'b0, tpm_i}));
    b_pgz_q <= 59'(a_rawz_q * $signed({1'b0, tpm_i}));

    c_w_q  <= w_d;
    c_qx_q <= rnd_q(b_pgx_q);
    c_qz_q <= rnd_q(b_pgz_q);

    d_ww_q <= 34'(c_w_q) * 34'(c_w_q);
    d_t_q  <= 18'(3 * tbbs_pkg::ONE_Q16) - {c_w_q, 1'b0};
    d_wk_q <= 34'(c_w_q) * 34'(omw);
    d_qx_q <= c_qx_q;
    d_qz_q <= c_qz_q;

    e_s_q  <= 52'(d_ww_q) * 52'(d_t_q);
    e_k_q  <= k_sum[32:16];
    e_qx_q <= d_qx_q;
    e_qz_q <= d_qz_q;

    f_blend_q <= (bl_full > 20'(tbbs_pkg::ONE_Q16)) ? 17'(tbbs_pkg::ONE_Q16) : bl_full[16:0];
    f_gx_q    <= 53'(e_qx_q * $signed({1'b0, e_k_q}));
    f_gz_q    <= 53'(e_qz_q * $signed({1'b0, e_k_q}));

    o_blend_q <= f_fl_q.miss ? '0 : f_blend_q;
    o_gx_q    <= f_fl_q.miss ? '0 : rnd_sat(f_gx_q);
    o_gz_q    <= f_fl_q.miss ? '0 : rnd_sat(f_gz_q);
  end

  assign done_o       = o_fl_q.vld;
  assign hit_o        = ~o_fl_q.miss;
  assign blend_o      = o_blend_q;
  assign gradient_x_o = o_gx_q;
  assign gradient_z_o = o_gz_q;

endmodule

`default_nettype wire
